// ===== rtl/core/lrlc_pkg.sv =====
// Shared types, constants and helper functions for the line rasterizer with link color.
// Depends on nothing; the divider and the top level import it.
`default_nettype none

package lrlc_pkg;

    localparam int NODE_BITS     = 10;
    localparam int DIV_BITS      = NODE_BITS + 1;
    localparam int QUOT_BITS     = 8;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam int ROOM_BITS     = 11;
    localparam int OFFSET_BITS   = 26;
    localparam int COLOR_BITS    = 24;

    localparam logic [QUOT_BITS-1:0]     DIVIDEND          = 8'hFF;
    localparam logic [CFG_DATA_BITS-1:0] IMAGE_WIDTH_RESET = 13'd1024;
    localparam logic [ROOM_BITS-1:0]     PALETTE_LIMIT     = 11'd150;
    localparam logic [7:0]               COLOR_MID_BYTE    = 8'h60;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_ROOM_COUNT  = 1'b1
    } t_cfg_index;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Remainder modulo 5 of an 11-bit sum; each nibble weight 16 is 1 modulo 5.
    function automatic logic [2:0] mod5(input logic [DIV_BITS-1:0] s);
        logic [5:0] n;
        logic [4:0] m;
        n = 6'(s[3:0]) + 6'(s[7:4]) + 6'(s[10:8]);
        m = 5'(n[3:0]) + 5'(n[5:4]);
        if (m >= 5'd15) begin
            m = m - 5'd15;
        end else if (m >= 5'd10) begin
            m = m - 5'd10;
        end else if (m >= 5'd5) begin
            m = m - 5'd5;
        end
        return m[2:0];
    endfunction

    function automatic logic [COLOR_BITS-1:0] palette_color(input logic [2:0] idx);
        logic [COLOR_BITS-1:0] c;
        case (idx)
            3'd0:    c = 24'hAA0000;
            3'd1:    c = 24'h0000AA;
            3'd2:    c = 24'hAAAA00;
            3'd3:    c = 24'h00AAAA;
            3'd4:    c = 24'hAA00AA;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lrlc_div.sv =====
// Restoring divider that divides the constant dividend by an 11-bit divisor, one bit a cycle.
// Depends on lrlc_pkg for widths and the dividend constant.
`default_nettype none

module lrlc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [lrlc_pkg::DIV_BITS-1:0]  i_divisor,
    output logic                                o_done,
    output logic      [lrlc_pkg::QUOT_BITS-1:0] o_quot
);
    import lrlc_pkg::*;

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);
    localparam int IDX_BITS = $clog2(QUOT_BITS);

    logic [DIV_BITS-1:0]  r_divisor;
    logic [DIV_BITS-1:0]  r_rem;
    logic [QUOT_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_done;

    logic [IDX_BITS-1:0]  bit_idx;
    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    diff;
    logic                 ge;
    logic [DIV_BITS-1:0]  n_rem;

    always_comb begin
        bit_idx = IDX_BITS'(r_cnt - CNT_BITS'(1));
        trial   = {r_rem, DIVIDEND[bit_idx]};
        diff    = trial - {1'b0, r_divisor};
        ge      = (trial >= {1'b0, r_divisor});
        n_rem   = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_BITS'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CNT_BITS'(QUOT_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quot    <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QUOT_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer_with_link_color.sv =====
// Line rasterizer with link color: a load beat sets up a Bresenham walk and its color,
// and each step beat on an active line yields one pixel. A load takes the palette path,
// or the two divisions of the shared restoring divider when the color needs them.
// A step beat runs walk update, offset multiply and output register in turn; o_stall holds
// off the next beat until the pixel is registered. Synchronous active-low reset clears the
// sequencer, the active-line flag and the output valid; width is 1024, room count 0.
`default_nettype none

module line_rasterizer_with_link_color #(
    parameter int COORD_BITS = 12,
    parameter int MAX_NODES  = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_cfg_we,
    input  wire logic [lrlc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [lrlc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,

    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_command,
    input  wire logic [COORD_BITS-1:0]              i_start_x,
    input  wire logic [COORD_BITS-1:0]              i_start_y,
    input  wire logic [COORD_BITS-1:0]              i_end_x,
    input  wire logic [COORD_BITS-1:0]              i_end_y,
    input  wire logic [lrlc_pkg::NODE_BITS-1:0]     i_from_node,
    input  wire logic [lrlc_pkg::NODE_BITS-1:0]     i_to_node,

    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [COORD_BITS-1:0]              o_pixel_x,
    output logic      [COORD_BITS-1:0]              o_pixel_y,
    output logic      [lrlc_pkg::OFFSET_BITS-1:0]   o_pixel_offset,
    output logic      [lrlc_pkg::COLOR_BITS-1:0]    o_pixel_color,
    output logic                                    o_last_pixel
);
    import lrlc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 2;
    localparam int PW = COORD_BITS + CFG_DATA_BITS;
    localparam int SW = (PW + 1 > OFFSET_BITS - 2) ? PW + 1 : OFFSET_BITS - 2;
    localparam logic [16:0] MAX_NODES_V = 17'(MAX_NODES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLOR,
        S_DIV_A,
        S_DIV_B,
        S_MUL,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CFG_DATA_BITS-1:0] r_image_width;
    logic [ROOM_BITS-1:0]  r_room_count;

    logic [CW-1:0]         r_cur_x, r_cur_y, r_target_x, r_target_y;
    logic [CW-1:0]         r_span_x, r_span_y;
    logic                  r_dir_x, r_dir_y;
    logic signed [EW-1:0]  r_err;
    logic                  r_busy;
    logic [COLOR_BITS-1:0] r_line_color;
    logic [NODE_BITS-1:0]  r_node_a, r_node_b;
    logic [QUOT_BITS-1:0]  r_quot_a;

    logic [CW-1:0]         r_px, r_py;
    logic                  r_last;
    logic [PW-1:0]         r_prod;

    logic                  r_out_valid;
    logic [CW-1:0]         r_out_x, r_out_y;
    logic [OFFSET_BITS-1:0] r_out_offset;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    logic                  accept;
    logic                  out_free;
    logic                  use_palette;
    logic                  div_start;
    logic [DIV_BITS-1:0]   div_divisor;
    logic                  div_done;
    logic [QUOT_BITS-1:0]  div_quot;

    logic signed [EW:0]    e2;
    logic signed [EW:0]    span_x_e, span_y_e;
    logic                  move_x, move_y;
    logic signed [EW-1:0]  n_err;
    logic [CW-1:0]         n_cur_x, n_cur_y;
    logic                  n_busy;
    logic [CW-1:0]         n_span_x, n_span_y;
    logic [SW-1:0]         offset_sum;
    logic [ROOM_BITS-1:0]  cfg_room;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        use_palette = (r_node_a[1:0] == 2'b00) || (r_room_count < PALETTE_LIMIT);
        div_start   = ((r_state == S_COLOR) && !use_palette)
                   || ((r_state == S_DIV_A) && div_done);
        div_divisor = (r_state == S_COLOR) ? {1'b0, r_node_a} + DIV_BITS'(1)
                                           : {1'b0, r_node_b} + DIV_BITS'(1);
    end

    lrlc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        e2       = $signed({r_err, 1'b0});
        span_x_e = $signed({3'b000, r_span_x});
        span_y_e = $signed({3'b000, r_span_y});
        move_y   = (e2 < span_x_e);
        move_x   = (e2 > -span_y_e);
        n_err    = r_err
                 + (move_y ? $signed({2'b00, r_span_x}) : $signed(EW'(0)))
                 - (move_x ? $signed({2'b00, r_span_y}) : $signed(EW'(0)));
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        if (move_y) begin
            n_cur_y = r_dir_y ? r_cur_y + CW'(1) : r_cur_y - CW'(1);
        end
        if (move_x) begin
            n_cur_x = r_dir_x ? r_cur_x + CW'(1) : r_cur_x - CW'(1);
        end
        n_busy   = (n_cur_x != r_target_x) || (n_cur_y != r_target_y);
        n_span_x = (i_end_x > i_start_x) ? i_end_x - i_start_x : i_start_x - i_end_x;
        n_span_y = (i_end_y > i_start_y) ? i_end_y - i_start_y : i_start_y - i_end_y;
        offset_sum = SW'(r_prod) + SW'(r_px);
        cfg_room   = i_cfg_data[ROOM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RESET;
            r_room_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                CFG_ROOM_COUNT: begin
                    if (17'(cfg_room) > MAX_NODES_V) begin
                        r_room_count <= ROOM_BITS'(MAX_NODES_V);
                    end else begin
                        r_room_count <= cfg_room;
                    end
                end
                default: r_room_count <= r_room_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_target_x   <= '0;
            r_target_y   <= '0;
            r_span_x     <= '0;
            r_span_y     <= '0;
            r_dir_x      <= 1'b0;
            r_dir_y      <= 1'b0;
            r_err        <= '0;
            r_line_color <= '0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_command == CMD_LOAD)) begin
                        r_span_x   <= n_span_x;
                        r_span_y   <= n_span_y;
                        r_dir_x    <= (i_start_x < i_end_x);
                        r_dir_y    <= (i_start_y < i_end_y);
                        r_err      <= $signed({2'b00, n_span_x}) - $signed({2'b00, n_span_y});
                        r_cur_x    <= i_start_x;
                        r_cur_y    <= i_start_y;
                        r_target_x <= i_end_x;
                        r_target_y <= i_end_y;
                        r_busy     <= (i_start_x != i_end_x) || (i_start_y != i_end_y);
                        r_node_a   <= i_from_node;
                        r_node_b   <= i_to_node;
                        r_state    <= S_COLOR;
                    end else if (accept && r_busy) begin
                        r_px    <= r_cur_x;
                        r_py    <= r_cur_y;
                        r_err   <= n_err;
                        r_cur_x <= n_cur_x;
                        r_cur_y <= n_cur_y;
                        r_busy  <= n_busy;
                        r_last  <= !n_busy;
                        r_state <= S_MUL;
                    end
                end
                S_COLOR: begin
                    if (use_palette) begin
                        r_line_color <= palette_color(mod5({1'b0, r_node_a} + {1'b0, r_node_b}));
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    if (div_done) begin
                        r_quot_a <= div_quot;
                        r_state  <= S_DIV_B;
                    end
                end
                S_DIV_B: begin
                    if (div_done) begin
                        r_line_color <= {r_quot_a, COLOR_MID_BYTE, div_quot};
                        r_state      <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_py * r_image_width;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= r_px;
                        r_out_y      <= r_py;
                        r_out_offset <= {offset_sum[OFFSET_BITS-3:0], 2'b00};
                        r_out_color  <= r_line_color;
                        r_out_last   <= r_last;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_offset = r_out_offset;
    assign o_pixel_color  = r_out_color;
    assign o_last_pixel   = r_out_last;

    a_busy_off_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_cur_x != r_target_x) || (r_cur_y != r_target_y)))
        else $error("Active line sits on its end point.");

    a_div_done_in_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_DIV_A) || (r_state == S_DIV_B)))
        else $error("Divider finished outside a color computation.");

    a_step_starts_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_STEP) && r_busy) |=> (r_state == S_MUL))
        else $error("Step beat on an active line did not start a pixel.");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && out_free) |=> o_valid)
        else $error("Pixel was not placed in the output register.");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for line_rasterizer_with_link_color: random and directed line loads and
// pixel steps, checked beat by beat against an in-bench Bresenham walk and color model.
// Depends on lrlc_pkg and the rasterizer top level.

module tb_top;
    import lrlc_pkg::*;

    localparam int CB          = 12;
    localparam int NUM_PHASES  = 8;
    localparam int ITEM_TARGET = 1650;

    typedef struct packed {
        logic          cmd;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        logic [9:0]    fn;
        logic [9:0]    tn;
    } t_line_cmd;

    typedef struct packed {
        logic [CB-1:0]          x;
        logic [CB-1:0]          y;
        logic [OFFSET_BITS-1:0] off;
        logic [COLOR_BITS-1:0]  color;
        logic                   last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic      in_valid = 1'b0;
    t_line_cmd held_cmd = '0;
    logic      rx_stall = 1'b0;

    logic                   dut_stall;
    logic                   dut_valid;
    logic [CB-1:0]          dut_x;
    logic [CB-1:0]          dut_y;
    logic [OFFSET_BITS-1:0] dut_off;
    logic [COLOR_BITS-1:0]  dut_color;
    logic                   dut_last;

    t_line_cmd cmd_q[$];
    t_pixel    pixel_q[$];
    t_line_cmd next_cmd;
    t_pixel    want_px;

    logic [CFG_DATA_BITS-1:0] cfg_width = IMAGE_WIDTH_RESET;
    logic [ROOM_BITS-1:0]     cfg_rooms = '0;

    logic [CB-1:0] walk_x = '0;
    logic [CB-1:0] walk_y = '0;
    logic [CB-1:0] goal_x = '0;
    logic [CB-1:0] goal_y = '0;
    logic [CB-1:0] run_x = '0;
    logic [CB-1:0] run_y = '0;
    logic          up_x = 1'b0;
    logic          up_y = 1'b0;
    int            walk_err = 0;
    logic [COLOR_BITS-1:0] walk_color = '0;
    logic          walk_busy = 1'b0;

    int  mismatch_count = 0;
    int  planned_items = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  sender_gaps = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  rx_cycle = 0;

    int phase_width[NUM_PHASES] = '{1, 4096, 8191, 640, 0, 1024, 33, 2000};
    int phase_rooms[NUM_PHASES] = '{0, 150, 149, 2047, 500, 1024, 150, 300};

    line_rasterizer_with_link_color u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (dut_stall),
        .i_command      (held_cmd.cmd),
        .i_start_x      (held_cmd.sx),
        .i_start_y      (held_cmd.sy),
        .i_end_x        (held_cmd.ex),
        .i_end_y        (held_cmd.ey),
        .i_from_node    (held_cmd.fn),
        .i_to_node      (held_cmd.tn),
        .o_valid        (dut_valid),
        .i_stall        (rx_stall),
        .o_pixel_x      (dut_x),
        .o_pixel_y      (dut_y),
        .o_pixel_offset (dut_off),
        .o_pixel_color  (dut_color),
        .o_last_pixel   (dut_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [COLOR_BITS-1:0] link_color(input logic [9:0] a,
                                                         input logic [9:0] b);
        int sel;
        logic [31:0] mix;
        if (a[1:0] == 2'b00 || cfg_rooms < ROOM_BITS'(150)) begin
            sel = (int'(a) + int'(b)) % 5;
            case (sel)
                0:       return 24'hAA0000;
                1:       return 24'h0000AA;
                2:       return 24'hAAAA00;
                3:       return 24'h00AAAA;
                default: return 24'hAA00AA;
            endcase
        end
        mix = ((32'd255 / (32'(a) + 1)) << 16) + (32'd255 / (32'(b) + 1)) + 32'h6000;
        return mix[COLOR_BITS-1:0];
    endfunction

    task automatic rasterize(input t_line_cmd c);
        t_pixel px;
        int e2;
        logic [31:0] addr;
        if (c.cmd == CMD_LOAD) begin
            run_x = (c.ex > c.sx) ? c.ex - c.sx : c.sx - c.ex;
            run_y = (c.ey > c.sy) ? c.ey - c.sy : c.sy - c.ey;
            up_x = c.sx < c.ex;
            up_y = c.sy < c.ey;
            walk_err = int'(run_x) - int'(run_y);
            walk_x = c.sx;
            walk_y = c.sy;
            goal_x = c.ex;
            goal_y = c.ey;
            walk_color = link_color(c.fn, c.tn);
            walk_busy = (c.sx != c.ex) || (c.sy != c.ey);
        end else if (walk_busy) begin
            px.x = walk_x;
            px.y = walk_y;
            addr = (32'(walk_x) + 32'(walk_y) * 32'(cfg_width)) * 32'd4;
            px.off = addr[OFFSET_BITS-1:0];
            e2 = walk_err * 2;
            if (e2 < int'(run_x)) begin
                walk_err = walk_err + int'(run_x);
                walk_y = up_y ? walk_y + 1'b1 : walk_y - 1'b1;
            end
            if (e2 > -int'(run_y)) begin
                walk_err = walk_err - int'(run_y);
                walk_x = up_x ? walk_x + 1'b1 : walk_x - 1'b1;
            end
            walk_busy = (walk_x != goal_x) || (walk_y != goal_y);
            px.color = walk_color;
            px.last = !walk_busy;
            pixel_q.push_back(px);
        end
    endtask

    // Sender: bursts of beats with random gaps, payload held while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !dut_stall) begin
                rasterize(held_cmd);
            end
            if (!in_valid || !dut_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    next_cmd = cmd_q.pop_front();
                    held_cmd <= next_cmd;
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (sender_gaps && $urandom_range(0, 3) != 0)
                                   ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: its own rotating stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_req && hold_cnt < 400) begin
                hold_cnt++;
                rx_stall <= 1'b1;
            end else begin
                case ((rx_cycle / 512) % 4)
                    0:       rx_stall <= 1'b0;
                    1:       rx_stall <= ($urandom_range(0, 1) == 1);
                    2:       rx_stall <= ((rx_cycle % 7) < 3);
                    default: rx_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && dut_valid && !rx_stall) begin
            if (pixel_q.size() == 0) begin
                $error("pixel beat with none expected: x=%0d y=%0d", dut_x, dut_y);
                mismatch_count++;
            end else begin
                want_px = pixel_q.pop_front();
                compare_field("pixel_x", 32'(want_px.x), 32'(dut_x));
                compare_field("pixel_y", 32'(want_px.y), 32'(dut_y));
                compare_field("pixel_offset", 32'(want_px.off), 32'(dut_off));
                compare_field("pixel_color", 32'(want_px.color), 32'(dut_color));
                compare_field("last_pixel", 32'(want_px.last), 32'(dut_last));
            end
        end
    end

    task automatic queue_cmd(input logic cmd, input int sx, input int sy, input int ex,
                             input int ey, input int fn, input int tn);
        t_line_cmd c;
        c.cmd = cmd;
        c.sx = CB'(sx);
        c.sy = CB'(sy);
        c.ex = CB'(ex);
        c.ey = CB'(ey);
        c.fn = 10'(fn);
        c.tn = 10'(tn);
        cmd_q.push_back(c);
    endtask

    task automatic queue_steps(input int n);
        repeat (n) begin
            queue_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input int fn, input int tn, input int steps);
        queue_cmd(CMD_LOAD, sx, sy, ex, ey, fn, tn);
        queue_steps(steps);
    endtask

    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 0;
        end else if (r == 1) begin
            return 4095;
        end
        return $urandom_range(0, 4095);
    endfunction

    function automatic int pick_node();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 0;
        end else if (r == 1) begin
            return 1023;
        end
        return $urandom_range(0, 1023);
    endfunction

    function automatic int near_coord(input int c, input int span);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return v;
    endfunction

    function automatic int line_length(input int sx, input int sy, input int ex, input int ey);
        int dx;
        int dy;
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        return (dx > dy) ? dx : dy;
    endfunction

    task automatic queue_random_line();
        int r;
        int sx;
        int sy;
        int ex;
        int ey;
        int len;
        int steps;
        r = $urandom_range(0, 99);
        sx = pick_coord();
        sy = pick_coord();
        if (r >= 70 && r < 80) begin
            ex = pick_coord();
            ey = pick_coord();
        end else if (r >= 88 && r < 94) begin
            ex = sx;
            ey = sy;
        end else begin
            ex = near_coord(sx, 24);
            ey = near_coord(sy, 24);
        end
        len = line_length(sx, sy, ex, ey);
        if (r < 70) begin
            steps = len;
            planned_items += 1 + len;
            queue_line(sx, sy, ex, ey, pick_node(), pick_node(), steps);
        end else if (r < 80) begin
            steps = $urandom_range(1, 40);
            planned_items += 1 + ((steps < len) ? steps : len);
            queue_line(sx, sy, ex, ey, pick_node(), pick_node(), steps);
        end else if (r < 88) begin
            planned_items += 1 + len;
            queue_line(sx, sy, ex, ey, pick_node(), pick_node(), len + $urandom_range(1, 3));
        end else if (r < 94) begin
            planned_items += 1;
            queue_line(sx, sy, ex, ey, pick_node(), pick_node(), $urandom_range(0, 2));
        end else if (r < 97) begin
            queue_steps($urandom_range(1, 3));
        end else begin
            planned_items += 1 + len / 2;
            queue_line(sx, sy, ex, ey, pick_node(), pick_node(), len / 2);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input int val);
        logic [CFG_DATA_BITS-1:0] v;
        v = CFG_DATA_BITS'(val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) begin
            cfg_width = v;
        end else begin
            cfg_rooms = (v[ROOM_BITS-1:0] > ROOM_BITS'(1024)) ? ROOM_BITS'(1024)
                                                                : v[ROOM_BITS-1:0];
        end
    endtask

    task automatic settle();
        int guard;
        while (cmd_q.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        guard = 0;
        while (pixel_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        int phase_goal;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gaps = 1'b1;
        queue_steps(1);
        queue_line(5, 5, 5, 5, 3, 3, 1);
        queue_line(0, 0, 4095, 4095, 1023, 1023, 3);
        queue_line(4095, 4095, 4092, 4094, 3, 7, 3);
        queue_line(10, 7, 13, 7, 0, 1, 3);
        queue_line(2, 9, 2, 5, 6, 2, 5);
        settle();

        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_ROOM_COUNT, 1024);
        queue_line(0, 4095, 1, 4095, 1, 0, 1);
        queue_line(4095, 0, 4095, 1, 1023, 1023, 1);
        queue_line(100, 100, 110, 103, 4, 9, 2);
        queue_line(0, 4095, 3, 4094, 5, 1022, 3);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                write_reg(CFG_IMAGE_WIDTH, $urandom_range(1, 8191));
                write_reg(CFG_ROOM_COUNT, $urandom_range(0, 2047));
            end else begin
                write_reg(CFG_IMAGE_WIDTH, phase_width[p]);
                write_reg(CFG_ROOM_COUNT, phase_rooms[p]);
            end
            sender_gaps = (p % 3) != 1;
            if (p == 3) begin
                hold_req = 1'b1;
            end
            phase_goal = planned_items + ITEM_TARGET / NUM_PHASES;
            while (planned_items < phase_goal) begin
                queue_random_line();
            end
            settle();
        end

        if (pixel_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pixel_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
